// ===== hw/rtl/julian_day_to_calendar_date_top_assert.svh =====
// assertion macros of the julian day converter checker
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_TOP_ASSERT_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_TOP_ASSERT_SVH

// clocked assertion, switched off while reset is held
`define JD2C_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked assertion that also watches the reset itself
`define JD2C_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/jd2c_pkg.sv =====
// shared constants and types of the julian day to calendar date converter
package jd2c_pkg;

  // pipeline depth, one register rank per stage
  localparam int unsigned NumStages = 12;

  // field widths
  localparam int unsigned JdnW    = 23;
  localparam int unsigned MinW    = 11;
  localparam int unsigned YearW   = 15;
  localparam int unsigned MonW    = 4;
  localparam int unsigned DomW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;

  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 40;

  // date chain constants
  localparam logic [23:0] JdnOffset    = 24'd68569;
  localparam logic [17:0] Cent4Days    = 18'd146097;
  localparam logic [14:0] RecipCent    = 15'((64'd1 << 32) / 64'd146097);
  localparam logic [11:0] YearScale    = 12'd4000;
  localparam logic [20:0] YearDiv      = 21'd1461001;
  localparam logic [23:0] RecipYear    = 24'(((64'd1 << 32) * 64'd4000) / 64'd1461001);
  localparam logic [10:0] QuadYearDays = 11'd1461;
  localparam logic [6:0]  CentYears    = 7'd100;
  localparam logic [14:0] YearBias     = 15'd4900;
  localparam logic [4:0]  DayOffset    = 5'd30;
  localparam logic [6:0]  MonScale     = 7'd80;
  localparam logic [11:0] MonDiv       = 12'd2447;
  localparam logic [15:0] RecipMonth   = 16'(((64'd1 << 20) * 64'd80) / 64'd2447);
  localparam logic [6:0]  DomRound     = 7'd79;
  localparam logic [7:0]  RecipFive    = 8'd205;
  localparam logic [3:0]  MonWrap      = 4'd11;
  localparam logic [3:0]  MonWrapSub   = 4'd10;
  localparam logic [3:0]  MonShift     = 4'd2;

  // time of day constants
  localparam logic [10:0] MinPerDay  = 11'd1440;
  localparam logic [5:0]  MinPerHour = 6'd60;
  localparam logic [10:0] RecipHour  = 11'((64'd1 << 16) / 64'd60);

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NumStages-1:0] en;
  } pipe_ctl_t;

endpackage

// ===== hw/rtl/jd2c_ctl.sv =====
// valid tracking and per-stage load enables of the converter pipeline
module jd2c_ctl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output jd2c_pkg::pipe_ctl_t ctl_o
);

  localparam int unsigned N = jd2c_pkg::NumStages;

  logic [N-1:0] valid_q, valid_d;
  logic [N-1:0] en;
  logic [N-1:0] ones;

  // a stage loads when the sink takes or some stage at or after it is empty
  always_comb begin
    ones = '1;
    for (int k = 0; k < N; k++) begin
      en[k] = m_ready_i || !(&(valid_q | ~(ones << k)));
    end
  end

  always_comb begin
    valid_d[0] = en[0] ? s_valid_i : valid_q[0];
    for (int k = 1; k < N; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_ready_o = en[0];
  assign m_valid_o = valid_q[N-1];
  assign ctl_o.en  = en;

endmodule

// ===== hw/rtl/jd2c_date.sv =====
// twelve stage datapath from julian day number to year, month and day
module jd2c_date (
  input  logic                              clk_i,
  input  jd2c_pkg::pipe_ctl_t               ctl_i,
  input  logic [jd2c_pkg::JdnW-1:0]         jdn_i,
  output logic signed [jd2c_pkg::YearW-1:0] year_o,
  output logic [jd2c_pkg::MonW-1:0]         month_o,
  output logic [jd2c_pkg::DomW-1:0]         dom_o
);

  // stage registers
  logic [23:0] a_q, a2_q, a3_q;
  logic [7:0]  q1e_q, q1e3_q, cent4_q;
  logic [25:0] m1_q;
  logic [15:0] b_q, y5_q, y6_q, y7_q;
  logic [6:0]  q2e_q, q2e6_q, yr_q;
  logic [27:0] t_q, m2_q;
  logic [14:0] yb5_q, yb6_q, yb7_q, yb8_q, yb9_q, yb10_q, year11_q, year12_q;
  logic [9:0]  c_q, c9_q;
  logic [3:0]  q3e_q, mq_q, mon11_q, mon12_q;
  logic [11:0] r10_q;
  logic [7:0]  dx_q;
  logic [4:0]  dom12_q;

  // next values
  logic [23:0] a_d;
  logic [40:0] prod1;
  logic [7:0]  q1e_d;
  logic [25:0] m1_d;
  logic [25:0] x4, diff4;
  logic [18:0] r4, r4c;
  logic        ge4;
  logic [7:0]  cent4_d;
  logic [15:0] b_d, y5_d;
  logic [39:0] prod2;
  logic [6:0]  q2e_d;
  logic [14:0] yb5_d;
  logic [27:0] t_d, m2_d, diff7;
  logic [21:0] r7;
  logic [6:0]  yr_d;
  logic [17:0] k8;
  logic [16:0] c8;
  logic [9:0]  c_d;
  logic [14:0] yb8_d;
  logic [25:0] prod3;
  logic [3:0]  q3e_d;
  logic [16:0] v10, m10, diff10;
  logic [12:0] r10, r10c;
  logic        ge10;
  logic [3:0]  mq_d;
  logic [11:0] r10_d, rp11;
  logic        wrap11;
  logic [3:0]  mon11_d;
  logic [14:0] year11_d;
  logic [15:0] prod12;

  always_comb begin
    // s1: shift the day count to a march based epoch
    a_d = {1'b0, jdn_i} + jd2c_pkg::JdnOffset;

    // s2: estimate of the 400 year cycle count
    prod1 = 41'({a_q, 2'b00}) * 41'(jd2c_pkg::RecipCent);
    q1e_d = prod1[39:32];

    // s3: days covered by the estimate
    m1_d = 26'(q1e_q) * 26'(jd2c_pkg::Cent4Days);

    // s4: remainder with one correction, day within the cycle is remainder / 4
    x4      = {a3_q, 2'b00};
    diff4   = x4 - m1_q;
    r4      = diff4[18:0];
    ge4     = r4 >= 19'(jd2c_pkg::Cent4Days);
    r4c     = r4 - 19'(jd2c_pkg::Cent4Days);
    cent4_d = ge4 ? q1e3_q + 8'd1 : q1e3_q;
    b_d     = ge4 ? r4c[17:2] : r4[17:2];

    // s5: year estimate within the cycle, year base from the cycle count
    y5_d  = b_q + 16'd1;
    prod2 = 40'(y5_d) * 40'(jd2c_pkg::RecipYear);
    q2e_d = prod2[38:32];
    yb5_d = 15'(15'(cent4_q) * 15'(jd2c_pkg::CentYears)) - jd2c_pkg::YearBias;

    // s6: scaled day and scaled estimate
    t_d  = 28'(y5_q) * 28'(jd2c_pkg::YearScale);
    m2_d = 28'(q2e_q) * 28'(jd2c_pkg::YearDiv);

    // s7: year correction
    diff7 = t_q - m2_q;
    r7    = diff7[21:0];
    yr_d  = q2e6_q + 7'(r7 >= 22'(jd2c_pkg::YearDiv));

    // s8: day within the march based year
    k8    = 18'(yr_q) * 18'(jd2c_pkg::QuadYearDays);
    c8    = 17'(y7_q) + 17'(jd2c_pkg::DayOffset) - 17'(k8[17:2]);
    c_d   = c8[9:0];
    yb8_d = yb7_q + 15'(yr_q);

    // s9: month index estimate
    prod3 = 26'(c_q) * 26'(jd2c_pkg::RecipMonth);
    q3e_d = prod3[23:20];

    // s10: month correction, keep the remainder for the day of month
    v10    = 17'(c9_q) * 17'(jd2c_pkg::MonScale);
    m10    = 17'(q3e_q) * 17'(jd2c_pkg::MonDiv);
    diff10 = v10 - m10;
    r10    = diff10[12:0];
    ge10   = r10 >= 13'(jd2c_pkg::MonDiv);
    r10c   = r10 - 13'(jd2c_pkg::MonDiv);
    mq_d   = q3e_q + 4'(ge10);
    r10_d  = ge10 ? r10c[11:0] : r10[11:0];

    // s11: day of month is the remainder / 80 rounded up, month wraps into next year
    rp11     = r10_q + 12'(jd2c_pkg::DomRound);
    wrap11   = mq_q >= jd2c_pkg::MonWrap;
    mon11_d  = wrap11 ? mq_q - jd2c_pkg::MonWrapSub : mq_q + jd2c_pkg::MonShift;
    year11_d = yb10_q + 15'(wrap11);

    // s12: divide by five
    prod12 = 16'(dx_q) * 16'(jd2c_pkg::RecipFive);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      a_q <= a_d;
    end
    if (ctl_i.en[1]) begin
      a2_q  <= a_q;
      q1e_q <= q1e_d;
    end
    if (ctl_i.en[2]) begin
      a3_q   <= a2_q;
      q1e3_q <= q1e_q;
      m1_q   <= m1_d;
    end
    if (ctl_i.en[3]) begin
      cent4_q <= cent4_d;
      b_q     <= b_d;
    end
    if (ctl_i.en[4]) begin
      y5_q  <= y5_d;
      q2e_q <= q2e_d;
      yb5_q <= yb5_d;
    end
    if (ctl_i.en[5]) begin
      y6_q   <= y5_q;
      q2e6_q <= q2e_q;
      t_q    <= t_d;
      m2_q   <= m2_d;
      yb6_q  <= yb5_q;
    end
    if (ctl_i.en[6]) begin
      y7_q  <= y6_q;
      yr_q  <= yr_d;
      yb7_q <= yb6_q;
    end
    if (ctl_i.en[7]) begin
      c_q   <= c_d;
      yb8_q <= yb8_d;
    end
    if (ctl_i.en[8]) begin
      c9_q  <= c_q;
      q3e_q <= q3e_d;
      yb9_q <= yb8_q;
    end
    if (ctl_i.en[9]) begin
      mq_q   <= mq_d;
      r10_q  <= r10_d;
      yb10_q <= yb9_q;
    end
    if (ctl_i.en[10]) begin
      dx_q     <= rp11[11:4];
      mon11_q  <= mon11_d;
      year11_q <= year11_d;
    end
    if (ctl_i.en[11]) begin
      dom12_q  <= prod12[14:10];
      mon12_q  <= mon11_q;
      year12_q <= year11_q;
    end
  end

  assign year_o  = year12_q;
  assign month_o = mon12_q;
  assign dom_o   = dom12_q;

endmodule

// ===== hw/rtl/jd2c_tod.sv =====
// minute of day to hour and minute, delayed to line up with the date path
module jd2c_tod (
  input  logic                             clk_i,
  input  jd2c_pkg::pipe_ctl_t              ctl_i,
  input  logic [jd2c_pkg::MinW-1:0]        min_of_day_i,
  output logic [jd2c_pkg::HourW-1:0]       hour_o,
  output logic [jd2c_pkg::MinuteW-1:0]     minute_o
);

  localparam int unsigned DelayN = jd2c_pkg::NumStages - 3;

  logic [10:0] mins_q, mins2_q;
  logic [4:0]  qe_q;
  logic [4:0]  hr3_q;
  logic [5:0]  mn3_q;
  logic [jd2c_pkg::HourW-1:0]   hr_dly_q [DelayN];
  logic [jd2c_pkg::MinuteW-1:0] mn_dly_q [DelayN];

  logic [10:0] mins_d;
  logic [21:0] prod2;
  logic [10:0] m3, r3;
  logic        ge3;
  logic [5:0]  r3c;

  always_comb begin
    // fold a count of a full day or more back into the day
    mins_d = (min_of_day_i >= jd2c_pkg::MinPerDay) ? min_of_day_i - jd2c_pkg::MinPerDay
                                                   : min_of_day_i;
    prod2  = 22'(mins_q) * 22'(jd2c_pkg::RecipHour);
    m3     = 11'(qe_q) * 11'(jd2c_pkg::MinPerHour);
    r3     = mins2_q - m3;
    ge3    = r3 >= 11'(jd2c_pkg::MinPerHour);
    r3c    = 6'(r3 - 11'(jd2c_pkg::MinPerHour));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      mins_q <= mins_d;
    end
    if (ctl_i.en[1]) begin
      mins2_q <= mins_q;
      qe_q    <= prod2[20:16];
    end
    if (ctl_i.en[2]) begin
      hr3_q <= qe_q + 5'(ge3);
      mn3_q <= ge3 ? r3c : r3[5:0];
    end
  end

  // delay line, one rank per remaining stage
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[3]) begin
      hr_dly_q[0] <= hr3_q;
      mn_dly_q[0] <= mn3_q;
    end
    for (int k = 1; k < DelayN; k++) begin
      if (ctl_i.en[k+3]) begin
        hr_dly_q[k] <= hr_dly_q[k-1];
        mn_dly_q[k] <= mn_dly_q[k-1];
      end
    end
  end

  assign hour_o   = hr_dly_q[DelayN-1];
  assign minute_o = mn_dly_q[DelayN-1];

endmodule

// ===== hw/rtl/julian_day_to_calendar_date_top.sv =====
// top level of the julian day number to calendar date and time converter
//
// Converts an integer Julian day number plus a minute of day into the
// proleptic Gregorian year (astronomical numbering, two's complement), month,
// day of month, hour and minute. One request goes in per clock and one result
// comes out per clock while the master side takes results; a request accepted
// at a clock edge passes through the 12 register ranks of the date chain to
// the master side (each constant division but the final divide by five is a
// reciprocal multiply followed by a back-multiply and a one-step correction in
// the stages after it; the divide by five is the reciprocal multiply alone).
// A stall on the master side holds the result in the last rank while the earlier
// ranks keep filling, so s_axis_tready only drops once every rank holds a request.
// Day numbers above the nominal range follow the same arithmetic and the year
// wraps in its 15-bit field; a minute count of 1440 or more is first reduced by
// one day without advancing the date. There is no configuration and no state
// beyond the pipeline itself.
module julian_day_to_calendar_date_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request side
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [22:0] julian_day_number, [33:23] minute_of_day, [39:34] zero
  input  logic [jd2c_pkg::InTdataW-1:0]     s_axis_tdata,
  // result side
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [14:0] year, [18:15] month, [23:19] day_of_month, [28:24] hour,
  // [34:29] minute, [39:35] zero
  output logic [jd2c_pkg::OutTdataW-1:0]    m_axis_tdata
);

  localparam int unsigned PadW = jd2c_pkg::OutTdataW - jd2c_pkg::YearW - jd2c_pkg::MonW
                                 - jd2c_pkg::DomW - jd2c_pkg::HourW - jd2c_pkg::MinuteW;

  jd2c_pkg::pipe_ctl_t ctl;

  logic [jd2c_pkg::JdnW-1:0]         julian_day_number;
  logic [jd2c_pkg::MinW-1:0]         minute_of_day;
  logic signed [jd2c_pkg::YearW-1:0] year;
  logic [jd2c_pkg::MonW-1:0]         month;
  logic [jd2c_pkg::DomW-1:0]         day_of_month;
  logic [jd2c_pkg::HourW-1:0]        hour;
  logic [jd2c_pkg::MinuteW-1:0]      minute;

  // unpack the request
  assign julian_day_number = s_axis_tdata[jd2c_pkg::JdnW-1:0];
  assign minute_of_day     = s_axis_tdata[jd2c_pkg::JdnW +: jd2c_pkg::MinW];

  // valid bits and stall handling for all ranks
  jd2c_ctl u_ctl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .ctl_o     (ctl)
  );

  // date chain
  jd2c_date u_date (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .jdn_i   (julian_day_number),
    .year_o  (year),
    .month_o (month),
    .dom_o   (day_of_month)
  );

  // hour and minute, aligned with the date chain
  jd2c_tod u_tod (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .min_of_day_i (minute_of_day),
    .hour_o       (hour),
    .minute_o     (minute)
  );

  // pack the result, first field in the low bits
  assign m_axis_tdata = {PadW'(0), minute, hour, day_of_month, month, year};

endmodule

// ===== hw/rtl/jd2c_chk.sv =====
// port level checks of the converter, bound to the top level
`include "julian_day_to_calendar_date_top_assert.svh"

module jd2c_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [jd2c_pkg::OutTdataW-1:0] m_axis_tdata
);

  // a stalled result stays put
  `JD2C_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "result changed while stalled")

  // with the sink free or the last rank empty the pipeline must take a request
  `JD2C_ASSERT(a_ready_free, clk_i, rst_ni,
    (m_axis_tready || !m_axis_tvalid) |-> s_axis_tready,
    "request refused with a free pipeline")

  // month and day always come out in range
  `JD2C_ASSERT(a_date_range, clk_i, rst_ni,
    m_axis_tvalid |-> (m_axis_tdata[18:15] != 4'd0) && (m_axis_tdata[18:15] <= 4'd12)
      && (m_axis_tdata[23:19] != 5'd0),
    "month or day out of range")

  // time of day always comes out in range
  `JD2C_ASSERT(a_time_range, clk_i, rst_ni,
    m_axis_tvalid |-> (m_axis_tdata[28:24] <= 5'd23) && (m_axis_tdata[34:29] <= 6'd59),
    "hour or minute out of range")

  // reset empties the pipeline
  `JD2C_ASSERT_NORST(a_rst_empty, clk_i, !rst_ni |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind julian_day_to_calendar_date_top jd2c_chk u_chk (.*);

// ===== bench/tb.sv =====
// testbench for the julian day number to calendar date and time converter
module tb;

  localparam int unsigned RandomRequests = 1200;
  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned DrainCycles    = 2 * jd2c_pkg::NumStages + 8;
  localparam logic [jd2c_pkg::JdnW-1:0] JdnTop = 23'd5373484;

  // one converted timestamp, fields in the reverse of their order on the result side
  typedef struct packed {
    logic [jd2c_pkg::YearW-1:0]   year;
    logic [jd2c_pkg::MonW-1:0]    month;
    logic [jd2c_pkg::DomW-1:0]    day_of_month;
    logic [jd2c_pkg::HourW-1:0]   hour;
    logic [jd2c_pkg::MinuteW-1:0] minute;
  } cal_date_t;

  class calendar_scoreboard;
    cal_date_t expected_dates[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
    endtask

    // fliegel / van flandern chain, all intermediates but the year non-negative
    function cal_date_t to_calendar(logic [jd2c_pkg::JdnW-1:0] jdn,
                                    logic [jd2c_pkg::MinW-1:0] mins);
      longint unsigned a, cent4, b, yr, c, mq, dom, wrap, mon, tod;
      longint          yr_full;
      cal_date_t       d;
      a       = 64'(jdn) + 68569;
      cent4   = (4 * a) / 146097;
      b       = a - (146097 * cent4 + 3) / 4;
      yr      = (4000 * (b + 1)) / 1461001;
      c       = b - (1461 * yr) / 4 + 31;
      mq      = (80 * c) / 2447;
      dom     = c - (2447 * mq) / 80;
      wrap    = mq / 11;
      mon     = mq + 2 - 12 * wrap;
      yr_full = 100 * (longint'(cent4) - 49) + longint'(yr) + longint'(wrap);
      tod     = 64'(mins) % 1440;
      d.year         = yr_full[jd2c_pkg::YearW-1:0];
      d.month        = mon[jd2c_pkg::MonW-1:0];
      d.day_of_month = dom[jd2c_pkg::DomW-1:0];
      d.hour         = 5'(tod / 60);
      d.minute       = 6'(tod % 60);
      return d;
    endfunction

    function void note_request(logic [jd2c_pkg::JdnW-1:0] jdn,
                               logic [jd2c_pkg::MinW-1:0] mins);
      expected_dates.push_back(to_calendar(jdn, mins));
    endfunction

    task check_result(logic [jd2c_pkg::OutTdataW-1:0] tdata);
      cal_date_t want;
      if (expected_dates.size() == 0) begin
        report_mismatch("unexpected result, tdata", tdata, 0);
        return;
      end
      want = expected_dates.pop_front();
      if (tdata[14:0] != want.year)
        report_mismatch("year", tdata[14:0], want.year);
      if (tdata[18:15] != want.month)
        report_mismatch("month", tdata[18:15], want.month);
      if (tdata[23:19] != want.day_of_month)
        report_mismatch("day_of_month", tdata[23:19], want.day_of_month);
      if (tdata[28:24] != want.hour)
        report_mismatch("hour", tdata[28:24], want.hour);
      if (tdata[34:29] != want.minute)
        report_mismatch("minute", tdata[34:29], want.minute);
      if (tdata[39:35] != '0)
        report_mismatch("padding", tdata[39:35], 0);
    endtask

    function int unsigned pending();
      return expected_dates.size();
    endfunction

    // anything still queued at the end never came out
    task flush_leftovers();
      while (expected_dates.size() != 0) begin
        void'(expected_dates.pop_front());
        report_mismatch("missing result, outstanding", expected_dates.size() + 1, 0);
      end
    endtask
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [jd2c_pkg::InTdataW-1:0]   s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [jd2c_pkg::OutTdataW-1:0]  m_axis_tdata;

  calendar_scoreboard    dates_sb;
  int unsigned           requests_sent;
  int unsigned           results_seen;
  int unsigned           quiet_cycles;

  julian_day_to_calendar_date_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // present one request, idling now and then outside requests 500 to 799, and hold it until taken
  task automatic send_request(input logic [jd2c_pkg::JdnW-1:0] jdn,
                              input logic [jd2c_pkg::MinW-1:0] mins);
    bit calm;
    calm = (requests_sent >= 500) && (requests_sent < 800);
    while (!calm && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, mins, jdn};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    dates_sb.note_request(jdn, mins);
    requests_sent++;
  endtask

  // result side: random back-pressure, none during a stretch in the middle
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      dates_sb.check_result(m_axis_tdata);
      results_seen++;
    end
    if ((results_seen >= 500) && (results_seen < 800))
      m_axis_tready <= 1'b1;
    else
      m_axis_tready <= ($urandom_range(99) >= 9);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [jd2c_pkg::JdnW-1:0] jdn;
    logic [jd2c_pkg::MinW-1:0] mins;
    int unsigned               pick;
    dates_sb      = new();
    requests_sent = 0;
    results_seen  = 0;
    quiet_cycles  = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes, calendar landmarks, out-of-range day numbers and
    // minute counts of a full day or more
    send_request(23'd0, 11'd0);
    send_request(JdnTop, 11'd1439);
    send_request(23'h7FFFFF, 11'h7FF);
    send_request(23'd5373485, 11'd1440);
    send_request(23'd2451545, 11'd720);    // start of year 2000
    send_request(23'd2451604, 11'd59);     // leap day 2000
    send_request(23'd2415079, 11'd60);     // end of feb 1900, not a leap year
    send_request(23'd2299160, 11'd1441);
    send_request(23'd2299161, 11'd1380);
    send_request(23'd1721425, 11'd1);      // around year zero
    send_request(23'd1721426, 11'd2000);
    send_request(23'd2460676, 11'd1024);
    send_request(23'd4194304, 11'd1023);
    send_request(23'h3FFFFF, 11'd1500);
    send_request(23'd5373483, 11'd600);

    for (int unsigned i = 0; i < RandomRequests; i++) begin
      pick = $urandom_range(99);
      if (pick < 75)
        jdn = 23'($urandom_range(JdnTop));
      else if (pick < 85)
        jdn = 23'($urandom_range(23'h7FFFFF, JdnTop + 1));
      else if (pick < 95)
        jdn = 23'($urandom_range(2500000, 2300000));
      else
        jdn = 23'($urandom_range(2000));
      if ($urandom_range(9) < 8)
        mins = 11'($urandom_range(1439));
      else
        mins = 11'($urandom_range(2047, 1440));
      send_request(jdn, mins);
    end
    s_axis_tvalid <= 1'b0;

    while (dates_sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    dates_sb.flush_leftovers();
    if (dates_sb.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/jd2c_pkg.sv
hw/rtl/jd2c_ctl.sv
hw/rtl/jd2c_date.sv
hw/rtl/jd2c_tod.sv
hw/rtl/julian_day_to_calendar_date_top.sv
hw/rtl/jd2c_chk.sv
bench/tb.sv
